@@ hw/rtl/bamd_pkg.sv @@
// Shared types, codes and decode functions of the bus access map decoder.
package bamd_pkg;

  localparam int unsigned MapBlocksDef  = 4096;
  localparam int unsigned BlockShiftDef = 12;
  localparam int unsigned EntryW        = 47;

  typedef enum logic [2:0] {
    MODE_RD_BYTE = 3'd0,
    MODE_RD_WORD = 3'd1,
    MODE_WR_BYTE = 3'd2,
    MODE_WR_WORD = 3'd3,
    MODE_LD_RMAP = 3'd4,
    MODE_LD_WMAP = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    RT_DIRECT = 3'd0,
    RT_SRAM   = 3'd1,
    RT_BWRAM  = 3'd2,
    RT_DRAM   = 3'd3,
    RT_DEV    = 3'd4,
    RT_OPEN   = 3'd5,
    RT_DROP   = 3'd6
  } route_e;

  localparam logic [1:0] WAIT_NONE   = 2'd0;
  localparam logic [1:0] WAIT_RECORD = 2'd1;
  localparam logic [1:0] WAIT_CLEAR  = 2'd2;
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_WAKE     = 2'd1;
  localparam logic [1:0] EV_EXEC     = 2'd2;

  // special region codes of a map entry
  localparam logic [4:0] MC_IO0    = 5'd0;
  localparam logic [4:0] MC_IO1    = 5'd1;
  localparam logic [4:0] MC_IO2    = 5'd2;
  localparam logic [4:0] MC_LOROM  = 5'd3;
  localparam logic [4:0] MC_HIROM  = 5'd4;
  localparam logic [4:0] MC_DEBUG  = 5'd6;
  localparam logic [4:0] MC_IO7    = 5'd7;
  localparam logic [4:0] MC_BWRAM  = 5'd8;
  localparam logic [4:0] MC_LOSRAM = 5'd11;
  localparam logic [4:0] MC_DEV12  = 5'd12;
  localparam logic [4:0] MC_DEV13  = 5'd13;
  localparam logic [4:0] MC_HISRAM = 5'd14;
  localparam logic [4:0] MC_IO15   = 5'd15;
  localparam logic [4:0] MC_DEV16  = 5'd16;
  localparam logic [4:0] MC_DEV17  = 5'd17;

  localparam logic [1:0] REG_SRAM_MASK = 2'd0;
  localparam logic [1:0] REG_WAKE_ONE  = 2'd1;
  localparam logic [1:0] REG_WAKE_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic [23:0]       address;
    logic [15:0]       write_data;
    logic [EntryW-1:0] map_entry;
    logic              in_dma;
    logic              copro_pc_set;
    logic              copro_waiting;
  } bamd_in_t;

  typedef struct packed {
    logic [2:0]  route;
    logic [4:0]  device_code;
    logic [31:0] target_offset;
    logic        is_write;
    logic [7:0]  byte_data;
    logic [8:0]  cycle_charge;
    logic [1:0]  wait_action;
    logic [1:0]  copro_event;
    logic        copro_executing;
    logic        sram_dirty;
    logic        last;
  } bamd_out_t;

  // classified access handed from front to back
  typedef struct packed {
    logic              wr;
    logic              word;
    logic              split;
    logic [23:0]       addr;
    logic [15:0]       wdata;
    logic              dma;
    logic              pcset;
    logic              waiting;
    logic [EntryW-1:0] e0;
    logic [EntryW-1:0] e1;
  } bamd_job_t;

  typedef struct packed {
    logic [8:0] charge;
    logic [1:0] waitc;
    logic [1:0] ev;
    logic       exe;
    logic       dset;
  } bamd_acc_t;

  typedef struct packed {
    logic [2:0]  route;
    logic [4:0]  dev;
    logic [31:0] off;
  } bamd_lane_t;

  typedef struct packed {
    logic [23:0] save_mask;
    logic [31:0] wake_one;
    logic [31:0] wake_two;
  } bamd_cfg_t;

  function automatic bamd_lane_t lane_f(logic wr, logic word, logic [EntryW-1:0] e,
                                        logic [23:0] a, logic [23:0] smask);
    bamd_lane_t l;
    logic [4:0]  code;
    logic [31:0] a32, m32, lo, hi, bw, lo16;
    code = e[4:0];
    a32  = {8'h00, a};
    m32  = {8'h00, smask};
    lo   = (((a32 & 32'hff0000) >> 1) | (a32 & 32'h7fff)) & m32;
    hi   = ((a32 & 32'h7fff) - 32'h6000 + ((a32 & 32'h0f0000) >> 3)) & m32;
    bw   = (a32 & 32'h7fff) - 32'h6000;
    lo16 = a32 & 32'hffff;
    l    = '{route: RT_OPEN, dev: 5'd0, off: 32'd0};
    if (e[5]) begin
      l = '{route: RT_DIRECT, dev: 5'd0, off: e[46:15] + lo16};
    end else if (wr) begin
      l.route = RT_DROP;
      case (code)
        MC_IO0, MC_IO1, MC_IO2, MC_IO7, MC_IO15: l = '{route: RT_DEV, dev: code, off: lo16};
        MC_LOROM, MC_HIROM: begin
          if (smask != 24'd0) begin
            l = '{route: RT_SRAM, dev: 5'd0, off: (code == MC_LOROM) ? lo : hi};
          end
        end
        MC_BWRAM: l = '{route: RT_BWRAM, dev: 5'd0, off: bw};
        MC_DEBUG: l = '{route: word ? RT_DRAM : RT_SRAM, dev: 5'd0, off: lo16};
        MC_LOSRAM: l = '{route: RT_SRAM, dev: 5'd0, off: lo16};
        MC_DEV13: l = '{route: RT_DRAM, dev: 5'd0, off: lo16};
        MC_DEV16, MC_DEV17: l = '{route: RT_DEV, dev: code, off: a32};
        default: l.route = RT_DROP;
      endcase
    end else begin
      case (code)
        MC_IO0, MC_IO1, MC_IO2, MC_IO7, MC_IO15: l = '{route: RT_DEV, dev: code, off: lo16};
        MC_LOROM, MC_LOSRAM: l = '{route: RT_SRAM, dev: 5'd0, off: lo};
        MC_HIROM, MC_HISRAM: l = '{route: RT_SRAM, dev: 5'd0, off: hi};
        MC_BWRAM: l = '{route: RT_BWRAM, dev: 5'd0, off: bw};
        MC_DEV12, MC_DEV16, MC_DEV17: l = '{route: RT_DEV, dev: code, off: a32};
        MC_DEV13: l = '{route: RT_DEV, dev: code, off: 32'h4800};
        default: l.route = RT_OPEN;
      endcase
    end
    return l;
  endfunction

  // access-wide effects: charge, wait action, coprocessor update, dirty set
  function automatic bamd_acc_t acc_f(logic wr, logic word, logic [EntryW-1:0] e,
                                      logic [23:0] a, logic dma, logic pcset,
                                      logic waiting, bamd_cfg_t cfg);
    bamd_acc_t r;
    logic [4:0]  code;
    logic [7:0]  speed;
    logic [31:0] off0;
    logic [8:0]  unit;
    code  = e[4:0];
    speed = e[14:7];
    off0  = e[46:15] + {16'h0000, a[15:0]};
    r     = '{charge: 9'd0, waitc: WAIT_NONE, ev: EV_NONE, exe: 1'b0, dset: 1'b0};
    if (e[5]) begin
      r.charge = word ? {speed, 1'b0} : {1'b0, speed};
      if (wr && (off0 == cfg.wake_one || off0 == cfg.wake_two)) begin
        r.ev  = EV_WAKE;
        r.exe = pcset;
      end else if (!wr && e[6]) begin
        r.waitc = WAIT_RECORD;
      end
    end else if (wr) begin
      case (code)
        MC_IO0:  r.charge = dma ? 9'd0 : (word ? 9'd12 : 9'd6);
        MC_IO1:  r.charge = word ? 9'd12 : 9'd6;
        MC_IO7:  r.charge = word ? 9'd16 : 9'd0;
        MC_LOSRAM: r.charge = 9'd8;
        default: r.charge = word ? 9'd16 : 9'd8;
      endcase
      r.dset = ((code == MC_LOROM || code == MC_HIROM) && cfg.save_mask != 24'd0) ||
               code == MC_BWRAM;
      if (code == MC_LOSRAM || (code == MC_DEBUG && !word)) begin
        r.ev  = EV_EXEC;
        r.exe = !waiting;
      end
    end else begin
      case (code)
        MC_IO0:           unit = dma ? 9'd0 : 9'd6;
        MC_IO1:           unit = 9'd6;
        MC_DEBUG, MC_IO7: unit = 9'd0;
        default:          unit = 9'd8;
      endcase
      r.charge = word ? {unit[7:0], 1'b0} : unit;
    end
    if (wr) r.waitc = WAIT_CLEAR;
    return r;
  endfunction

endpackage

@@ hw/rtl/bamd_fifo.sv @@
// Two-entry job queue between the decode front and the lane back end.
module bamd_fifo
  import bamd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bamd_job_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output bamd_job_t data_o
);

  bamd_job_t  slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = count_q[1];
  assign valid_o = count_q != 2'd0;
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop) rptr_q <= !rptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ hw/rtl/bamd_front.sv @@
// Front end: accepts items, maintains the read and write maps, looks up entries.
module bamd_front
  import bamd_pkg::*;
#(
  parameter int unsigned MAP_BLOCKS  = MapBlocksDef,
  parameter int unsigned BLOCK_SHIFT = BlockShiftDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bamd_in_t  in_data_i,
  output logic      push_o,
  output bamd_job_t push_data_o,
  input  logic      full_i
);

  localparam int unsigned IdxW = $clog2(MAP_BLOCKS);
  localparam logic [23:0] BMask = 24'((32'd1 << BLOCK_SHIFT) - 32'd1);

  typedef enum logic [1:0] {S_IDLE, S_E0, S_E1, S_PUSH} state_e;

  logic [EntryW-1:0] rmap [MAP_BLOCKS];
  logic [EntryW-1:0] wmap [MAP_BLOCKS];
  logic [EntryW-1:0] rdata_q;

  state_e    state_q;
  bamd_job_t job_q;
  logic      acc;
  logic      is_access, rd_en;
  logic      in_wr, in_word;
  logic [23:0]     a1;
  logic [31:0]     blk0, blk1;
  logic [IdxW-1:0] ridx, idx0;

  assign in_ready_o = state_q == S_IDLE;
  assign acc        = in_valid_i && in_ready_o;
  assign is_access  = in_data_i.mode <= MODE_WR_WORD;
  assign in_wr      = in_data_i.mode == MODE_WR_BYTE || in_data_i.mode == MODE_WR_WORD;
  assign in_word    = in_data_i.mode == MODE_RD_WORD || in_data_i.mode == MODE_WR_WORD;
  assign a1         = job_q.addr + 24'd1;
  assign blk0       = {8'h00, in_data_i.address} >> BLOCK_SHIFT;
  assign blk1       = {8'h00, a1} >> BLOCK_SHIFT;
  assign idx0       = blk0[IdxW-1:0];
  assign ridx       = (state_q == S_IDLE) ? idx0 : blk1[IdxW-1:0];
  assign rd_en      = (acc && is_access) || (state_q == S_E0 && job_q.split);

  assign push_o      = state_q == S_PUSH;
  assign push_data_o = job_q;

  always_ff @(posedge clk_i) begin
    if (acc && in_data_i.mode == MODE_LD_RMAP) rmap[idx0] <= in_data_i.map_entry;
    if (acc && in_data_i.mode == MODE_LD_WMAP) wmap[idx0] <= in_data_i.map_entry;
  end

  // the write flag is steady for both lookups of one item
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= ((state_q == S_IDLE) ? in_wr : job_q.wr) ? wmap[ridx] : rmap[ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (acc && is_access) begin
            job_q.wr      <= in_wr;
            job_q.word    <= in_word;
            job_q.split   <= in_word && ((in_data_i.address & BMask) == BMask);
            job_q.addr    <= in_data_i.address;
            job_q.wdata   <= in_data_i.write_data;
            job_q.dma     <= in_data_i.in_dma;
            job_q.pcset   <= in_data_i.copro_pc_set;
            job_q.waiting <= in_data_i.copro_waiting;
            state_q       <= S_E0;
          end
        end
        S_E0: begin
          job_q.e0 <= rdata_q;
          job_q.e1 <= rdata_q;
          state_q  <= job_q.split ? S_E1 : S_PUSH;
        end
        S_E1: begin
          job_q.e1 <= rdata_q;
          state_q  <= S_PUSH;
        end
        S_PUSH: begin
          if (!full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/bamd_back.sv @@
// Back end: turns a queued access into byte beats and keeps the dirty flag.
module bamd_back
  import bamd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bamd_cfg_t cfg_i,
  input  logic      job_valid_i,
  input  bamd_job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bamd_out_t out_data_o
);

  logic       lane_q, dirty_q, out_valid_q;
  bamd_out_t  out_q;
  logic       nsw, can_load, emit, lane_last, dnew;
  logic [23:0] a1;
  bamd_acc_t  acc0, acc1;
  bamd_lane_t l0, l1;
  bamd_out_t  beat;

  assign nsw  = job_i.word && !job_i.split;
  assign a1   = job_i.addr + 24'd1;
  assign acc0 = acc_f(job_i.wr, nsw, job_i.e0, job_i.addr, job_i.dma, job_i.pcset,
                      job_i.waiting, cfg_i);
  assign acc1 = acc_f(job_i.wr, 1'b0, job_i.e1, a1, job_i.dma, job_i.pcset,
                      job_i.waiting, cfg_i);
  assign l0   = lane_f(job_i.wr, nsw, job_i.e0, job_i.addr, cfg_i.save_mask);
  assign l1   = lane_f(job_i.wr, nsw, job_i.e1, a1, cfg_i.save_mask);
  assign dnew = dirty_q || acc0.dset || (job_i.split && acc1.dset);

  assign can_load  = !out_valid_q || out_ready_i;
  assign emit      = job_valid_i && can_load;
  assign lane_last = lane_q || !job_i.word;
  assign pop_o     = emit && lane_last;

  always_comb begin
    beat            = '0;
    beat.is_write   = job_i.wr;
    beat.sram_dirty = dnew;
    if (!lane_q) begin
      beat.route       = l0.route;
      beat.device_code = l0.dev;
      beat.target_offset = l0.off;
      beat.byte_data   = job_i.wr ? job_i.wdata[7:0] : 8'h00;
      beat.last        = !job_i.word;
      if (!nsw) begin
        beat.wait_action     = acc0.waitc;
        beat.copro_event     = acc0.ev;
        beat.copro_executing = acc0.exe;
        beat.cycle_charge    = job_i.word ? 9'd0 : acc0.charge;
      end
    end else begin
      beat.route       = l1.route;
      beat.device_code = l1.dev;
      beat.target_offset = l1.off;
      beat.byte_data   = job_i.wr ? job_i.wdata[15:8] : 8'h00;
      beat.last        = 1'b1;
      if (job_i.split) begin
        beat.wait_action     = acc1.waitc;
        beat.copro_event     = acc1.ev;
        beat.copro_executing = acc1.exe;
        beat.cycle_charge    = acc0.charge + acc1.charge;
      end else begin
        beat.wait_action     = acc0.waitc;
        beat.copro_event     = acc0.ev;
        beat.copro_executing = acc0.exe;
        beat.cycle_charge    = acc0.charge;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= beat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q      <= 1'b0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (can_load) out_valid_q <= job_valid_i;
      if (emit) begin
        lane_q <= !lane_last;
        if (lane_last) dirty_q <= dnew;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/bus_access_map_decoder_core.sv @@
// Top level of the bus access map decoder: config registers, front, queue, back.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | bamd_in_t
//  out     | output    | out_valid/out_ready| bamd_out_t, one beat per byte
//  apb     | input     | psel/penable/pready| save_mask, wake_one, wake_two
//
// An access passes the front steps accept with map read, entry capture and queue
// push, with a second map read before the push when a word crosses a block end;
// a map load is written when accepted. The back emits one beat per cycle from the
// queue head while the output is not stalled, and pops a word only after its second
// beat. The single map read port sets the front rate. Reset clears control state
// and the dirty flag; map contents are undefined until loaded. Output stalls hold
// the beat register and back up through the queue to in_ready.
module bus_access_map_decoder_core
  import bamd_pkg::*;
#(
  parameter int unsigned MAP_BLOCKS  = MapBlocksDef,
  parameter int unsigned BLOCK_SHIFT = BlockShiftDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bamd_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bamd_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bamd_cfg_t cfg_q;
  logic      push, full, pop, jvalid, wr_en;
  bamd_job_t push_job, head_job;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.save_mask <= 24'd0;
      cfg_q.wake_one  <= 32'hffff_ffff;
      cfg_q.wake_two  <= 32'hffff_ffff;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SRAM_MASK: cfg_q.save_mask <= pwdata[23:0];
        REG_WAKE_ONE:  cfg_q.wake_one  <= pwdata;
        REG_WAKE_TWO:  cfg_q.wake_two  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SRAM_MASK: prdata = {8'h00, cfg_q.save_mask};
      REG_WAKE_ONE:  prdata = cfg_q.wake_one;
      REG_WAKE_TWO:  prdata = cfg_q.wake_two;
      default:       prdata = 32'd0;
    endcase
  end

  bamd_front #(
    .MAP_BLOCKS (MAP_BLOCKS),
    .BLOCK_SHIFT(BLOCK_SHIFT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_data_o(push_job),
    .full_i     (full)
  );

  bamd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (jvalid),
    .data_o     (head_job)
  );

  bamd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(jvalid),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ verif/tb_bus_access_map_decoder_core.sv @@
// Self-checking testbench of the bus access map decoder core.
`timescale 1ns / 100ps

module tb_bus_access_map_decoder_core;
  import bamd_pkg::*;

  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;
  localparam int unsigned CycleLimit = 1000000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  bamd_in_t    in_data_i;
  bamd_out_t   out_data_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  bus_access_map_decoder_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [EntryW-1:0] rmap_q [4096];
  logic [EntryW-1:0] wmap_q [4096];
  bit                loaded_q [4096];
  logic              dirty_q;
  logic [23:0]       mask_q;
  logic [31:0]       wake_one_q, wake_two_q;
  bamd_out_t         beat_q [$];
  logic [11:0]       blk_list [$];

  int  errors, beats_seen, items_sent, cycles;
  bit  quiet, hold_req;
  int  rx_cnt, hold_cnt;
  logic [11:0] wake_blk, wake_low;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d beats pending", $realtime, beat_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  task automatic decode_access(input bit wr, input bit word, input logic [23:0] a,
                               input logic [15:0] data, input bit dma, input bit pcset,
                               input bit waiting, output bamd_out_t b0,
                               output bamd_out_t b1, output int n);
    logic [EntryW-1:0] e;
    logic [4:0]  code;
    logic [7:0]  speed;
    logic [31:0] base, a32, lo, hi, lo16;
    logic [8:0]  charge;
    logic [1:0]  wt, ev;
    logic        exe;
    logic [23:0] ai;
    bamd_out_t   b [2];
    e     = wr ? wmap_q[a[23:12]] : rmap_q[a[23:12]];
    code  = e[4:0];
    speed = e[14:7];
    base  = e[46:15];
    n     = word ? 2 : 1;
    wt    = WAIT_NONE;
    ev    = EV_NONE;
    exe   = 1'b0;
    for (int i = 0; i < 2; i++) b[i] = '0;
    for (int i = 0; i < n; i++) begin
      ai   = a + 24'(i);
      a32  = {8'h00, ai};
      lo   = (((a32 & 32'hff0000) >> 1) | (a32 & 32'h7fff)) & {8'h00, mask_q};
      hi   = ((a32 & 32'h7fff) - 32'h6000 + ((a32 & 32'h0f0000) >> 3)) & {8'h00, mask_q};
      lo16 = a32 & 32'hffff;
      b[i].is_write  = wr;
      b[i].byte_data = wr ? data[8*i +: 8] : 8'h00;
      if (e[5]) begin
        b[i].route = RT_DIRECT;
        b[i].target_offset = base + {16'h0, a[15:0]} + 32'(i);
      end else if (wr) begin
        case (code)
          MC_IO0, MC_IO1, MC_IO2, MC_IO7, MC_IO15: begin
            b[i].route = RT_DEV; b[i].device_code = code; b[i].target_offset = lo16;
          end
          MC_LOROM, MC_HIROM: begin
            if (mask_q != 24'd0) begin
              b[i].route = RT_SRAM;
              b[i].target_offset = (code == MC_LOROM) ? lo : hi;
              dirty_q = 1'b1;
            end else begin
              b[i].route = RT_DROP;
            end
          end
          MC_BWRAM: begin
            b[i].route = RT_BWRAM; b[i].target_offset = (a32 & 32'h7fff) - 32'h6000;
            dirty_q = 1'b1;
          end
          MC_DEBUG: begin
            b[i].target_offset = lo16;
            if (word) begin
              b[i].route = RT_DRAM;
            end else begin
              b[i].route = RT_SRAM; ev = EV_EXEC; exe = !waiting;
            end
          end
          MC_LOSRAM: begin
            b[i].route = RT_SRAM; b[i].target_offset = lo16; ev = EV_EXEC; exe = !waiting;
          end
          MC_DEV13: begin
            b[i].route = RT_DRAM; b[i].target_offset = lo16;
          end
          MC_DEV16, MC_DEV17: begin
            b[i].route = RT_DEV; b[i].device_code = code; b[i].target_offset = a32;
          end
          default: b[i].route = RT_DROP;
        endcase
      end else begin
        case (code)
          MC_IO0, MC_IO1, MC_IO2, MC_IO7, MC_IO15: begin
            b[i].route = RT_DEV; b[i].device_code = code; b[i].target_offset = lo16;
          end
          MC_LOROM, MC_LOSRAM: begin
            b[i].route = RT_SRAM; b[i].target_offset = lo;
          end
          MC_HIROM, MC_HISRAM: begin
            b[i].route = RT_SRAM; b[i].target_offset = hi;
          end
          MC_BWRAM: begin
            b[i].route = RT_BWRAM; b[i].target_offset = (a32 & 32'h7fff) - 32'h6000;
          end
          MC_DEV12, MC_DEV16, MC_DEV17: begin
            b[i].route = RT_DEV; b[i].device_code = code; b[i].target_offset = a32;
          end
          MC_DEV13: begin
            b[i].route = RT_DEV; b[i].device_code = code; b[i].target_offset = 32'h4800;
          end
          default: b[i].route = RT_OPEN;
        endcase
      end
    end
    if (e[5]) begin
      charge = 9'(speed) * 9'(n);
      if (wr) begin
        // wake compares the first lane's offset only
        if (b[0].target_offset == wake_one_q || b[0].target_offset == wake_two_q) begin
          ev = EV_WAKE; exe = pcset;
        end
      end else if (e[6]) begin
        wt = WAIT_RECORD;
      end
    end else if (wr) begin
      case (code)
        MC_IO0:    charge = dma ? 9'd0 : (word ? 9'd12 : 9'd6);
        MC_IO1:    charge = word ? 9'd12 : 9'd6;
        MC_IO7:    charge = word ? 9'd16 : 9'd0;
        MC_LOSRAM: charge = 9'd8;
        default:   charge = word ? 9'd16 : 9'd8;
      endcase
    end else begin
      case (code)
        MC_IO0:           charge = dma ? 9'd0 : 9'd6;
        MC_IO1:           charge = 9'd6;
        MC_DEBUG, MC_IO7: charge = 9'd0;
        default:          charge = 9'd8;
      endcase
      charge = charge * 9'(n);
    end
    if (wr) wt = WAIT_CLEAR;
    for (int i = 0; i < n; i++) b[i].sram_dirty = dirty_q;
    b[n-1].cycle_charge    = charge;
    b[n-1].wait_action     = wt;
    b[n-1].copro_event     = ev;
    b[n-1].copro_executing = exe;
    b[n-1].last            = 1'b1;
    b0 = b[0];
    b1 = b[1];
  endtask

  task automatic predict_beats(input bamd_in_t it);
    bamd_out_t r0, r1, s0, s1;
    int  n;
    bit  wr, word;
    case (it.mode)
      MODE_LD_RMAP: rmap_q[it.address[23:12]] = it.map_entry;
      MODE_LD_WMAP: wmap_q[it.address[23:12]] = it.map_entry;
      MODE_RD_BYTE, MODE_RD_WORD, MODE_WR_BYTE, MODE_WR_WORD: begin
        wr   = (it.mode == MODE_WR_BYTE || it.mode == MODE_WR_WORD);
        word = (it.mode == MODE_RD_WORD || it.mode == MODE_WR_WORD);
        if (word && it.address[11:0] == 12'hfff) begin
          // word at block end: two byte accesses, charges summed on the last beat
          decode_access(wr, 1'b0, it.address, {8'h00, it.write_data[7:0]}, it.in_dma,
                        it.copro_pc_set, it.copro_waiting, r0, r1, n);
          decode_access(wr, 1'b0, it.address + 24'd1, {8'h00, it.write_data[15:8]},
                        it.in_dma, it.copro_pc_set, it.copro_waiting, s0, s1, n);
          s0.cycle_charge = s0.cycle_charge + r0.cycle_charge;
          r0.cycle_charge = 9'd0;
          r0.last         = 1'b0;
          r0.sram_dirty   = dirty_q;
          beat_q.push_back(r0);
          beat_q.push_back(s0);
        end else begin
          decode_access(wr, word, it.address, it.write_data, it.in_dma, it.copro_pc_set,
                        it.copro_waiting, r0, r1, n);
          beat_q.push_back(r0);
          if (n == 2) beat_q.push_back(r1);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------- result checking ----------------
  task automatic cmp_field(input string name, input logic [31:0] exp_v,
                           input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected 0x%0h actual 0x%0h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    bamd_out_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (beat_q.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: expected none actual 0x%0h", $realtime, out_data_o);
      end else begin
        x = beat_q.pop_front();
        cmp_field("route", x.route, out_data_o.route);
        cmp_field("device_code", x.device_code, out_data_o.device_code);
        cmp_field("target_offset", x.target_offset, out_data_o.target_offset);
        cmp_field("is_write", x.is_write, out_data_o.is_write);
        cmp_field("byte_data", x.byte_data, out_data_o.byte_data);
        cmp_field("cycle_charge", x.cycle_charge, out_data_o.cycle_charge);
        cmp_field("wait_action", x.wait_action, out_data_o.wait_action);
        cmp_field("copro_event", x.copro_event, out_data_o.copro_event);
        cmp_field("copro_executing", x.copro_executing, out_data_o.copro_executing);
        cmp_field("sram_dirty", x.sram_dirty, out_data_o.sram_dirty);
        cmp_field("last", x.last, out_data_o.last);
      end
    end
  end

  // ---------------- receiver ----------------
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i = 1'b0;
    end else if (quiet) begin
      out_ready_i = 1'b1;
    end else if (rx_cnt > 0) begin
      rx_cnt--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready_i = 1'b0;
      rx_cnt = $urandom_range(0, 11);
    end else begin
      out_ready_i = 1'b1;
      rx_cnt = $urandom_range(0, 24);
    end
  end

  // ---------------- sender ----------------
  task automatic send_item(input bamd_in_t it);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beats(it);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic bamd_in_t rand_fields();
    bamd_in_t it;
    it.mode          = MODE_RD_BYTE;
    it.address       = 24'($urandom);
    it.write_data    = 16'($urandom);
    it.map_entry     = EntryW'({$urandom, $urandom});
    it.in_dma        = 1'($urandom);
    it.copro_pc_set  = 1'($urandom);
    it.copro_waiting = 1'($urandom);
    return it;
  endfunction

  function automatic logic [EntryW-1:0] rand_entry();
    logic [EntryW-1:0] e;
    e      = EntryW'({$urandom, $urandom});
    e[4:0] = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 17)) : 5'($urandom);
    e[5]   = ($urandom_range(0, 2) == 0);
    return e;
  endfunction

  task automatic load_block(input logic [11:0] blk, input logic [EntryW-1:0] re,
                            input logic [EntryW-1:0] we);
    bamd_in_t it;
    it = rand_fields();
    it.address[23:12] = blk;
    it.mode = MODE_LD_RMAP;
    it.map_entry = re;
    send_item(it);
    it = rand_fields();
    it.address[23:12] = blk;
    it.mode = MODE_LD_WMAP;
    it.map_entry = we;
    send_item(it);
    if (!loaded_q[blk]) blk_list.push_back(blk);
    loaded_q[blk] = 1'b1;
  endtask

  task automatic send_access(input logic [2:0] mode, input logic [11:0] blk,
                             input logic [11:0] low);
    bamd_in_t it;
    it = rand_fields();
    it.mode = mode;
    // a split word needs the next block loaded as well
    if ((mode == MODE_RD_WORD || mode == MODE_WR_WORD) && low == 12'hfff &&
        !loaded_q[blk + 12'd1]) low = 12'hffe;
    it.address = {blk, low};
    send_item(it);
  endtask

  task automatic wait_drained();
    while (beat_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_SRAM_MASK: mask_q = v[23:0];
      REG_WAKE_ONE:  wake_one_q = v;
      REG_WAKE_TWO:  wake_two_q = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [23:0] m, input logic [31:0] w1,
                            input logic [31:0] w2);
    wait_drained();
    apb_write(REG_SRAM_MASK, {8'h00, m});
    apb_write(REG_WAKE_ONE, w1);
    apb_write(REG_WAKE_TWO, w2);
  endtask

  // direct write entry on one block, with wake one aimed at one of its offsets
  task automatic arm_wake(input logic [23:0] m, input logic [31:0] w2);
    logic [EntryW-1:0] we;
    we = rand_entry();
    we[5] = 1'b1;
    wake_blk = 12'($urandom);
    wake_low = 12'($urandom);
    load_block(wake_blk, rand_entry(), we);
    set_config(m, we[46:15] + {16'h0, wake_blk[3:0], wake_low}, w2);
  endtask

  task automatic run_random(input int count);
    int r;
    bamd_in_t it;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        load_block((blk_list.size() < 48) ? 12'($urandom)
                   : blk_list[$urandom_range(0, blk_list.size() - 1)],
                   rand_entry(), rand_entry());
      end else if (r < 8) begin
        it = rand_fields();
        it.mode = r[0] ? ModeSpare6 : ModeSpare7;
        send_item(it);
      end else if (r < 18) begin
        send_access(($urandom_range(0, 1) != 0) ? MODE_WR_WORD : MODE_WR_BYTE,
                    wake_blk, wake_low);
      end else begin
        send_access(3'($urandom_range(0, 3)), blk_list[$urandom_range(0, blk_list.size() - 1)],
                    ($urandom_range(0, 5) == 0) ? 12'hfff : 12'($urandom));
      end
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    logic [EntryW-1:0] e;
    e = rand_entry();
    e[5:0] = {1'b0, MC_LOROM};
    load_block(12'h000, e, e);
    send_access(MODE_WR_BYTE, 12'h000, 12'h123);
    send_access(MODE_RD_WORD, 12'h000, 12'h000);
  endtask

  task automatic test_region_codes();
    logic [EntryW-1:0] e;
    for (int c = 0; c < 20; c++) begin
      e = EntryW'({$urandom, $urandom});
      e[5:0] = {1'b0, 5'(c == 19 ? 31 : c)};
      load_block(12'h7ff, e, e);
      send_access(3'(c % 4), 12'h7ff, 12'($urandom));
    end
    e = '1;
    load_block(12'hfff, e, e);
    e = '0;
    e[5] = 1'b1;
    load_block(12'h001, e, e);
    send_access(MODE_RD_WORD, 12'hfff, 12'hfff);
  endtask

  task automatic test_block_split();
    send_access(MODE_WR_WORD, 12'hfff, 12'hfff);
    send_access(MODE_RD_WORD, 12'h000, 12'hfff);
    send_access(MODE_WR_WORD, 12'h000, 12'hfff);
  endtask

  task automatic test_config_sweep();
    arm_wake(24'hffffff, 32'h0);
    run_random(300);
    arm_wake(24'($urandom), 32'hffffffff);
    run_random(300);
    arm_wake(24'h000000, $urandom);
    run_random(300);
    arm_wake(24'h000001, 32'hffffffff);
    run_random(250);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    run_random(60);
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    run_random(150);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; beats_seen = 0; items_sent = 0; cycles = 0;
    quiet = 1'b0; hold_req = 1'b0; rx_cnt = 0; hold_cnt = 0;
    dirty_q = 1'b0; mask_q = '0; wake_one_q = '1; wake_two_q = '1;
    wake_blk = 12'h000; wake_low = 12'h000;
    for (int i = 0; i < 4096; i++) loaded_q[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    test_reset_defaults();
    test_region_codes();
    test_block_split();
    test_config_sweep();
    test_backpressure();
    test_quiet_tail();

    while (beat_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d input items and %0d result beats over %0d map blocks,",
             items_sent, beats_seen, blk_list.size());
    $display("all region codes, block-end splits, sram masks and wake offsets");
    if (errors == 0 && beat_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d beats never seen", errors, beat_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
